### rtl/ssfc_pkg.sv
// Shared types, codes and reset constants for the seek, sweep and fire controller.
package ssfc_pkg;

    // Event kinds carried on the input tuser.
    typedef enum logic [1:0] {
        OP_SENSE = 2'd0,
        OP_SLOW  = 2'd1,
        OP_PWM   = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    // Configuration register indexes.
    localparam logic [2:0] CFG_QUARTER_TURN = 3'd0;
    localparam logic [2:0] CFG_HALF_TURN    = 3'd1;
    localparam logic [2:0] CFG_FIRE_HOLD    = 3'd2;
    localparam logic [2:0] CFG_COOLDOWN     = 3'd3;
    localparam logic [2:0] CFG_PULSE_SHORT  = 3'd4;
    localparam logic [2:0] CFG_PULSE_LONG   = 3'd5;
    localparam logic [2:0] CFG_FRAME_LAST   = 3'd6;

    localparam logic [4:0] QUARTER_TURN_RESET = 5'd8;
    localparam logic [4:0] HALF_TURN_RESET    = 5'd16;
    localparam logic [4:0] FIRE_HOLD_RESET    = 5'd5;
    localparam logic [4:0] COOLDOWN_RESET     = 5'd10;
    localparam logic [5:0] PULSE_SHORT_RESET  = 6'd1;
    localparam logic [5:0] PULSE_LONG_RESET   = 6'd5;
    localparam logic [5:0] FRAME_LAST_RESET   = 6'd40;

    // System modes.
    localparam logic [1:0] MODE_INIT    = 2'd0;
    localparam logic [1:0] MODE_MANUAL  = 2'd1;
    localparam logic [1:0] MODE_SEARCH  = 2'd2;
    localparam logic [1:0] MODE_ENGAGED = 2'd3;

    // Motor commands.
    localparam logic [1:0] MOT_STOP  = 2'd0;
    localparam logic [1:0] MOT_FWD   = 2'd1;
    localparam logic [1:0] MOT_LEFT  = 2'd2;
    localparam logic [1:0] MOT_RIGHT = 2'd3;

    typedef struct packed {
        logic [4:0] quarter_turn_ticks;
        logic [4:0] half_turn_ticks;
        logic [4:0] fire_hold_ticks;
        logic [4:0] cooldown_ticks;
        logic [5:0] pulse_short_slots;
        logic [5:0] pulse_long_slots;
        logic [5:0] frame_last_slot;
    } t_cfg;

    typedef struct packed {
        logic target_right;
        logic target_center;
        logic target_left;
        logic manual_fire;
        logic auto_mode;
    } t_sense;

    function automatic logic [2:0] colour_of(input logic [1:0] mode);
        logic [2:0] c;
        unique case (mode)
            MODE_MANUAL:  c = 3'd2;
            MODE_SEARCH:  c = 3'd3;
            MODE_ENGAGED: c = 3'd4;
            default:      c = 3'd6;
        endcase
        return c;
    endfunction

endpackage

### rtl/seek_sweep_and_fire_controller_core.sv
// Top level of the seek, sweep and fire controller: ports, registers, pipeline.
//
//  Channel  | Direction | Handshake                   | Payload
//  ---------+-----------+-----------------------------+------------------------------------
//  s_axis   | in        | s_axis_tvalid/s_axis_tready | tdata: sense flags, tuser: opcode
//  m_axis   | out       | m_axis_tvalid/m_axis_tready | tdata: motor, colour, servos, mode
//  cfg      | in        | i_cfg_we                    | i_cfg_addr, i_cfg_data
//
// Every item yields exactly one result item, showing the controller state after it.
// An accepted item waits in the input register and is folded into the state once the
// result register is free or being emptied, which loads the result register; one item per
// cycle is sustained while the output is not stalled. While a result waits, the input
// register takes one more item and then stalls the input; a stalled output holds both
// stages.
// Reset is synchronous and active low and restores every configuration register and
// all controller state to its power-on value.
module seek_sweep_and_fire_controller_core import ssfc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] auto_mode, [1] manual_fire, [2] target_left, [3] target_center,
    // [4] target_right, [7:5] zero
    input  logic [7:0]  s_axis_tdata,
    // [1:0] opcode
    input  logic [1:0]  s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] motor_command, [4:2] status_colour, [5] servo_a_level,
    // [6] servo_b_level, [8:7] system_mode, [15:9] zero
    output logic [15:0] m_axis_tdata,

    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [5:0]  i_cfg_data
);

    t_cfg       r_cfg;

    logic       r_in_valid;
    t_opcode    r_in_op;
    t_sense     r_in_sense;

    logic        r_out_valid;
    logic [15:0] r_out_data;

    logic       step;
    logic [1:0] drive_next;
    logic [1:0] mode_next;
    logic [5:0] pulse_width;
    logic [1:0] levels_next;

    // Configuration writes land directly; writes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.quarter_turn_ticks <= QUARTER_TURN_RESET;
            r_cfg.half_turn_ticks    <= HALF_TURN_RESET;
            r_cfg.fire_hold_ticks    <= FIRE_HOLD_RESET;
            r_cfg.cooldown_ticks     <= COOLDOWN_RESET;
            r_cfg.pulse_short_slots  <= PULSE_SHORT_RESET;
            r_cfg.pulse_long_slots   <= PULSE_LONG_RESET;
            r_cfg.frame_last_slot    <= FRAME_LAST_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_QUARTER_TURN: r_cfg.quarter_turn_ticks <= i_cfg_data[4:0];
                CFG_HALF_TURN:    r_cfg.half_turn_ticks    <= i_cfg_data[4:0];
                CFG_FIRE_HOLD:    r_cfg.fire_hold_ticks    <= i_cfg_data[4:0];
                CFG_COOLDOWN:     r_cfg.cooldown_ticks     <= i_cfg_data[4:0];
                CFG_PULSE_SHORT:  r_cfg.pulse_short_slots  <= i_cfg_data;
                CFG_PULSE_LONG:   r_cfg.pulse_long_slots   <= i_cfg_data;
                CFG_FRAME_LAST:   r_cfg.frame_last_slot    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The buffered item is processed when the result register is free or being emptied.
    assign step          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op    <= t_opcode'(s_axis_tuser);
            r_in_sense <= t_sense'(s_axis_tdata[4:0]);
        end
    end

    ssfc_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_opcode      (r_in_op),
        .i_sense       (r_in_sense),
        .i_cfg         (r_cfg),
        .o_drive_next  (drive_next),
        .o_mode_next   (mode_next),
        .o_pulse_width (pulse_width)
    );

    ssfc_pwm u_pwm (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_opcode      (r_in_op),
        .i_cfg         (r_cfg),
        .i_pulse_width (pulse_width),
        .o_levels_next (levels_next)
    );

    // The result register holds until taken; it reloads on every processed item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_data <= {7'd0, mode_next, levels_next[1], levels_next[0],
                           colour_of(mode_next), drive_next};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

### rtl/ssfc_ctrl.sv
// Mode, drive, sweep and fire sequencing state for the controller.
module ssfc_ctrl import ssfc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  t_opcode    i_opcode,
    input  t_sense     i_sense,
    input  t_cfg       i_cfg,
    output logic [1:0] o_drive_next,
    output logic [1:0] o_mode_next,
    output logic [5:0] o_pulse_width
);

    typedef enum logic [4:0] {
        SW_STANDBY  = 5'b00001,
        SW_LEFT90   = 5'b00010,
        SW_RIGHT90  = 5'b00100,
        SW_LEFT180  = 5'b01000,
        SW_RIGHT180 = 5'b10000
    } t_sweep;

    typedef enum logic [2:0] {
        FS_STANDBY = 3'b001,
        FS_PULLED  = 3'b010,
        FS_COOL    = 3'b100
    } t_fire;

    t_sweep     r_sweep, n_sweep;
    t_fire      r_fire, n_fire;
    logic [4:0] r_sweep_count, n_sweep_count;
    logic [4:0] r_fire_count, n_fire_count;
    logic       r_last_right, n_last_right;
    logic       r_armed, n_armed;
    logic       r_auto_fire, n_auto_fire;
    logic [5:0] r_pulse_width, n_pulse_width;
    logic [1:0] r_drive, n_drive;
    logic [1:0] r_mode, n_mode;

    logic [4:0] sweep_limit;
    t_sweep     sweep_after;

    always_comb begin
        unique case (r_sweep)
            SW_LEFT90: begin
                sweep_limit = i_cfg.quarter_turn_ticks;
                sweep_after = SW_RIGHT180;
            end
            SW_RIGHT90: begin
                sweep_limit = i_cfg.quarter_turn_ticks;
                sweep_after = SW_LEFT180;
            end
            SW_LEFT180: begin
                sweep_limit = i_cfg.half_turn_ticks;
                sweep_after = SW_RIGHT180;
            end
            default: begin
                sweep_limit = i_cfg.half_turn_ticks;
                sweep_after = SW_LEFT180;
            end
        endcase
    end

    always_comb begin
        n_sweep       = r_sweep;
        n_fire        = r_fire;
        n_sweep_count = r_sweep_count;
        n_fire_count  = r_fire_count;
        n_last_right  = r_last_right;
        n_armed       = r_armed;
        n_auto_fire   = r_auto_fire;
        n_pulse_width = r_pulse_width;
        n_drive       = r_drive;
        n_mode        = r_mode;

        case (i_opcode)
            OP_SENSE: begin
                if (i_sense.auto_mode) begin
                    if (i_sense.target_center) begin
                        n_mode        = MODE_ENGAGED;
                        n_drive       = MOT_FWD;
                        n_sweep       = SW_STANDBY;
                        n_sweep_count = '0;
                    end else begin
                        n_mode = MODE_SEARCH;
                        if (i_sense.target_left) begin
                            n_drive      = MOT_RIGHT;
                            n_sweep      = SW_STANDBY;
                            n_last_right = 1'b0;
                            n_armed      = 1'b0;
                        end else if (i_sense.target_right) begin
                            n_drive      = MOT_LEFT;
                            n_sweep      = SW_STANDBY;
                            n_last_right = 1'b1;
                            n_armed      = 1'b0;
                        end else begin
                            unique case (r_sweep)
                                SW_STANDBY: begin
                                    n_sweep       = r_last_right ? SW_RIGHT90 : SW_LEFT90;
                                    n_sweep_count = '0;
                                end
                                SW_LEFT90, SW_LEFT180: begin
                                    n_drive = MOT_LEFT;
                                    n_armed = 1'b1;
                                end
                                SW_RIGHT90, SW_RIGHT180: begin
                                    n_drive = MOT_RIGHT;
                                    n_armed = 1'b1;
                                end
                                default: n_sweep = SW_STANDBY;
                            endcase
                        end
                    end
                end else begin
                    n_mode  = MODE_MANUAL;
                    n_sweep = SW_STANDBY;
                end

                if (n_mode == MODE_SEARCH) begin
                    n_auto_fire = 1'b0;
                end else if (n_mode == MODE_ENGAGED) begin
                    n_auto_fire = 1'b1;
                end

                unique case (r_fire)
                    FS_STANDBY: begin
                        if ((i_sense.auto_mode && n_auto_fire) ||
                            (!i_sense.auto_mode && i_sense.manual_fire)) begin
                            n_fire       = FS_PULLED;
                            n_fire_count = '0;
                        end
                        n_pulse_width = i_cfg.pulse_short_slots;
                    end
                    FS_PULLED: begin
                        n_armed       = 1'b1;
                        n_pulse_width = i_cfg.pulse_long_slots;
                    end
                    default: begin
                        n_armed       = 1'b1;
                        n_pulse_width = i_cfg.pulse_short_slots;
                    end
                endcase
            end
            OP_SLOW: begin
                if (r_armed) begin
                    if (r_fire == FS_PULLED) begin
                        if (r_fire_count == i_cfg.fire_hold_ticks) begin
                            n_fire       = FS_COOL;
                            n_fire_count = '0;
                            n_armed      = 1'b0;
                        end else begin
                            n_fire_count = r_fire_count + 5'd1;
                        end
                    end else if (r_fire == FS_COOL) begin
                        if (r_fire_count == i_cfg.cooldown_ticks) begin
                            n_fire  = FS_STANDBY;
                            n_armed = 1'b0;
                        end else begin
                            n_fire_count = r_fire_count + 5'd1;
                        end
                    end
                    // Any turning sweep state counts toward its turn length.
                    if (r_sweep != SW_STANDBY) begin
                        if (r_sweep_count == sweep_limit) begin
                            n_sweep       = sweep_after;
                            n_sweep_count = '0;
                            n_armed       = 1'b0;
                        end else begin
                            n_sweep_count = r_sweep_count + 5'd1;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep       <= SW_STANDBY;
            r_fire        <= FS_STANDBY;
            r_sweep_count <= '0;
            r_fire_count  <= '0;
            r_last_right  <= 1'b0;
            r_armed       <= 1'b0;
            r_auto_fire   <= 1'b0;
            r_pulse_width <= PULSE_SHORT_RESET;
            r_drive       <= MOT_STOP;
            r_mode        <= MODE_INIT;
        end else if (i_step) begin
            r_sweep       <= n_sweep;
            r_fire        <= n_fire;
            r_sweep_count <= n_sweep_count;
            r_fire_count  <= n_fire_count;
            r_last_right  <= n_last_right;
            r_armed       <= n_armed;
            r_auto_fire   <= n_auto_fire;
            r_pulse_width <= n_pulse_width;
            r_drive       <= n_drive;
            r_mode        <= n_mode;
        end
    end

    assign o_drive_next  = n_drive;
    assign o_mode_next   = n_mode;
    assign o_pulse_width = r_pulse_width;

endmodule

### rtl/ssfc_pwm.sv
// Servo slot counter and the two complementary servo pulse levels.
module ssfc_pwm import ssfc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  t_opcode    i_opcode,
    input  t_cfg       i_cfg,
    input  logic [5:0] i_pulse_width,
    output logic [1:0] o_levels_next
);

    logic [5:0] r_slot, n_slot;
    logic [1:0] r_levels, n_levels;
    logic       lvl_a, lvl_b;

    always_comb begin
        lvl_a = (r_slot < i_pulse_width);
        // The second servo runs the other width from the first.
        if (i_pulse_width == i_cfg.pulse_long_slots) begin
            lvl_b = (r_slot < i_cfg.pulse_short_slots);
        end else begin
            lvl_b = (r_slot < i_cfg.pulse_long_slots);
        end

        n_slot   = r_slot;
        n_levels = r_levels;
        if (i_opcode == OP_PWM) begin
            n_levels = {lvl_b, lvl_a};
            n_slot   = (r_slot == i_cfg.frame_last_slot) ? 6'd0 : r_slot + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot   <= '0;
            r_levels <= '0;
        end else if (i_step) begin
            r_slot   <= n_slot;
            r_levels <= n_levels;
        end
    end

    assign o_levels_next = n_levels;

endmodule
